// ----- src/rrss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_pkg
// shared constants, codes and types of the round-robin slice scheduler
// ----------------------------------------------------------------------------
package rrss_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int OP_W    = 2;
  localparam int ID_W    = 22;
  localparam int SLICE_W = 10;
  localparam int CODE_W  = 5;
  localparam int KIND_W  = 3;

  localparam int IN_FIELDS_W  = ID_W + SLICE_W + CODE_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ID_W + CODE_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_TICK     = 2'd2
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    EV_ADDED    = 3'd0,
    EV_DUP      = 3'd1,
    EV_FULL     = 3'd2,
    EV_REMOVED  = 3'd3,
    EV_NOTFOUND = 3'd4,
    EV_IDLE     = 3'd5,
    EV_START    = 3'd6,
    EV_STOP     = 3'd7
  } event_e;

  typedef struct packed {
    logic [ID_W-1:0]    ident;
    logic [SLICE_W-1:0] slice;
    logic [CODE_W-1:0]  code;
  } entry_t;

  typedef struct packed {
    event_e            kind;
    logic [ID_W-1:0]   ident;
    logic [CODE_W-1:0] sig;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } tbl_req_t;

endpackage

// ----- src/rrss_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_table
// client table memory: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module rrss_table (
  input  logic              clk_i,
  input  rrss_pkg::tbl_req_t req_i,
  output rrss_pkg::entry_t   rdata_o
);
  import rrss_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rrss_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_ctrl
// sequencer: scans the table one slot per cycle, updates valid flags,
// fill count and the active slice, and produces the result beats
// ----------------------------------------------------------------------------
module rrss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [rrss_pkg::OP_W-1:0] in_op_i,
  input  rrss_pkg::entry_t   in_entry_i,
  output rrss_pkg::tbl_req_t tbl_req_o,
  input  rrss_pkg::entry_t   tbl_rdata_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output rrss_pkg::result_t  res_o
);
  import rrss_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_STOP = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] s,
                                                 input logic [CNT_W-1:0]  n);
    logic [CNT_W-1:0] nx;
    nx = CNT_W'(s) + CNT_W'(1);
    return (nx < n) ? nx[SLOT_W-1:0] : '0;
  endfunction

  state_e                 state_q, state_d;
  op_e                    op_q, op_d;
  entry_t                 item_q, item_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]       used_q, used_d;
  logic [SLOT_W-1:0]      next_slot_q, next_slot_d;
  logic                   running_q, running_d;
  logic [SLICE_W-1:0]     remain_q, remain_d;
  logic [ID_W-1:0]        act_id_q, act_id_d;
  logic [CODE_W-1:0]      act_code_q, act_code_d;
  logic [SLOT_W-1:0]      iss_slot_q, iss_slot_d;
  logic [CNT_W-1:0]       iss_left_q, iss_left_d;
  logic                   chk_vld_q, chk_vld_d;
  logic [SLOT_W-1:0]      chk_slot_q, chk_slot_d;
  result_t                res_q, res_d;

  logic              accept;
  logic              scan_init;
  logic [SLOT_W-1:0] start_slot;
  logic [SLOT_W-1:0] init_slot;
  logic              hit;
  logic              scan_done;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign start_slot = (CNT_W'(next_slot_q) < used_q) ? next_slot_q : '0;
  assign init_slot  = (state_q == ST_STOP || op_e'(in_op_i) == OP_TICK) ? start_slot : '0;
  assign hit        = chk_vld_q && valid_q[chk_slot_q] &&
                      (op_q == OP_TICK || tbl_rdata_i.ident == item_q.ident);
  assign scan_done  = hit || (iss_left_q == '0);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    item_d      = item_q;
    valid_d     = valid_q;
    used_d      = used_q;
    next_slot_d = next_slot_q;
    running_d   = running_q;
    remain_d    = remain_q;
    act_id_d    = act_id_q;
    act_code_d  = act_code_q;
    iss_slot_d  = iss_slot_q;
    iss_left_d  = iss_left_q;
    chk_vld_d   = 1'b0;
    chk_slot_d  = chk_slot_q;
    res_d       = res_q;
    tbl_req_o   = '0;
    in_ready_o  = (state_q == ST_IDLE);
    res_valid_o = 1'b0;
    scan_init   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d   = op_e'(in_op_i);
          item_d = in_entry_i;
          case (op_e'(in_op_i))
            OP_REGISTER, OP_REMOVE: begin
              scan_init = 1'b1;
            end
            OP_TICK: begin
              if (!running_q) begin
                scan_init = 1'b1;
              end else if (remain_q > SLICE_W'(1)) begin
                remain_d = remain_q - SLICE_W'(1);
              end else begin
                // slice over: stop beat first, then look for the next client
                remain_d  = '0;
                running_d = 1'b0;
                res_d     = '{kind: EV_STOP, ident: act_id_q, sig: act_code_q, last: 1'b0};
                state_d   = ST_STOP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_STOP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          scan_init = 1'b1;
        end
      end
      ST_SCAN: begin
        // issue side: one table read per cycle
        if (iss_left_q != '0) begin
          tbl_req_o.re    = 1'b1;
          tbl_req_o.raddr = iss_slot_q;
          chk_vld_d       = 1'b1;
          chk_slot_d      = iss_slot_q;
          iss_slot_d      = wrap_inc(iss_slot_q, used_q);
          iss_left_d      = iss_left_q - CNT_W'(1);
        end
        // check side: data of the slot read last cycle
        if (scan_done) begin
          state_d = ST_RESP;
          res_d   = '{kind: EV_IDLE, ident: '0, sig: '0, last: 1'b1};
          case (op_q)
            OP_REGISTER: begin
              res_d.ident = item_q.ident;
              if (hit) begin
                res_d.kind = EV_DUP;
              end else if (used_q >= CNT_W'(TABLE_DEPTH)) begin
                res_d.kind = EV_FULL;
              end else begin
                tbl_req_o.we    = 1'b1;
                tbl_req_o.waddr = used_q[SLOT_W-1:0];
                tbl_req_o.wdata = item_q;
                valid_d[used_q[SLOT_W-1:0]] = 1'b1;
                used_d     = used_q + CNT_W'(1);
                res_d.kind = EV_ADDED;
              end
            end
            OP_REMOVE: begin
              res_d.ident = item_q.ident;
              if (hit) begin
                valid_d[chk_slot_q] = 1'b0;
                res_d.kind = EV_REMOVED;
              end else begin
                res_d.kind = EV_NOTFOUND;
              end
            end
            OP_TICK: begin
              if (hit) begin
                act_id_d    = tbl_rdata_i.ident;
                act_code_d  = tbl_rdata_i.code;
                remain_d    = (tbl_rdata_i.slice == '0) ? SLICE_W'(1) : tbl_rdata_i.slice;
                running_d   = 1'b1;
                next_slot_d = wrap_inc(chk_slot_q, used_q);
                res_d       = '{kind: EV_START, ident: tbl_rdata_i.ident,
                                sig: tbl_rdata_i.code, last: 1'b1};
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (scan_init) begin
      iss_slot_d = init_slot;
      iss_left_d = used_q;
      chk_vld_d  = 1'b0;
      state_d    = ST_SCAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      used_q      <= '0;
      next_slot_q <= '0;
      running_q   <= 1'b0;
      remain_q    <= '0;
      act_id_q    <= '0;
      act_code_q  <= '0;
      iss_left_q  <= '0;
      chk_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      used_q      <= used_d;
      next_slot_q <= next_slot_d;
      running_q   <= running_d;
      remain_q    <= remain_d;
      act_id_q    <= act_id_d;
      act_code_q  <= act_code_d;
      iss_left_q  <= iss_left_d;
      chk_vld_q   <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    item_q     <= item_d;
    iss_slot_q <= iss_slot_d;
    chk_slot_q <= chk_slot_d;
    res_q      <= res_d;
  end

  assign res_o = res_q;

endmodule

// ----- src/rrss_obuf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_obuf
// output register: holds one result beat so the sequencer can move on
// ----------------------------------------------------------------------------
module rrss_obuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rrss_pkg::result_t in_res_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rrss_pkg::result_t out_res_o
);
  import rrss_pkg::*;

  logic    full_q;
  result_t data_q;

  assign in_ready_o  = !full_q || out_ready_i;
  assign out_valid_o = full_q;
  assign out_res_o   = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      full_q <= 1'b1;
    end else if (out_ready_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_res_i;
    end
  end

endmodule

// ----- src/round_robin_slice_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler
// client table with round-robin time-slice rotation driven by tick beats
// ----------------------------------------------------------------------------
// channel  dir  handshake                  payload
// s_axis   in   s_axis_tvalid/tready       tuser: operation; tdata: id, slice, code
// m_axis   out  m_axis_tvalid/tready       tuser: event kind; tdata: id, signal;
//                                          tlast: final beat of one input beat
//
// one input beat at a time; a scan walks the used slots of the table memory
// at one slot per cycle through its single read port; register, remove,
// ticks with no running slice and slice-ending ticks scan (the last after
// one stop beat); a mid-slice tick only counts down the slice, with no scan.
// reset clears control, valid flags and fill count; table contents are not
// cleared and need no clearing pass.
// a full output register with m_axis_tready low holds the sequencer in its
// response state; the next input beat is taken while a result still waits.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input beats
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rrss_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // client_id, slice_ms, signal_code
  input  logic [rrss_pkg::OP_W-1:0]       s_axis_tuser,  // operation
  // result beats
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rrss_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // target_id, target_signal
  output logic [rrss_pkg::KIND_W-1:0]     m_axis_tuser,  // event_kind
  output logic                           m_axis_tlast   // last
);
  import rrss_pkg::*;

  entry_t   in_entry;
  tbl_req_t tbl_req;
  entry_t   tbl_rdata;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  result_t  out_res;

  // unpack input fields, lowest bits first
  assign in_entry.ident = s_axis_tdata[ID_W-1:0];
  assign in_entry.slice = s_axis_tdata[ID_W +: SLICE_W];
  assign in_entry.code  = s_axis_tdata[ID_W+SLICE_W +: CODE_W];

  // table memory: id, slice and code of every slot
  rrss_table u_table (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata)
  );

  // sequencer: scan, read-modify-write of flags and counters, result beats
  rrss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_entry_i  (in_entry),
    .tbl_req_o   (tbl_req),
    .tbl_rdata_i (tbl_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register decoupling the sequencer from downstream stalls
  rrss_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_res_i    (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  // pack result fields, lowest bits first, zero fill to whole bytes
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_res.sig, out_res.ident};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

// ----- src/rrss_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_checker
// port-level checks on the result stream of the scheduler
// ----------------------------------------------------------------------------
module rrss_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rrss_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [rrss_pkg::KIND_W-1:0]     m_axis_tuser,
  input logic                           m_axis_tlast
);
  import rrss_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // a stop is never the final beat, everything else is
  a_stop_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == EV_STOP |-> !m_axis_tlast)
    else $error("stop beat marked last");

  a_other_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != EV_STOP |-> m_axis_tlast)
    else $error("non-stop beat not marked last");

  // idle carries no client
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == EV_IDLE |-> m_axis_tdata == '0)
    else $error("idle beat with nonzero payload");

  // only start and stop carry a signal code
  a_sig_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != EV_START && m_axis_tuser != EV_STOP |->
      m_axis_tdata[ID_W +: CODE_W] == '0)
    else $error("signal code on table event");

endmodule

bind round_robin_slice_scheduler rrss_checker u_rrss_checker (.*);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the round-robin slice scheduler: a scoreboard
// class tracks the client table and slice rotation, queues the result beats
// every accepted input beat should cause and checks each output beat
// against the oldest one; directed corner cases come first, then random
// register / remove / tick traffic with random gaps on both streams
// ----------------------------------------------------------------------------
module tb;
  import rrss_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;  // ignored by the block
  localparam int RAND_ITEMS  = 1100;
  localparam int STALL_LIMIT = 4000;   // cycles with no beat on either side
  localparam int TAIL_CYCLES = 64;     // settle time after the last result
  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

  // model of the client table; predicts result beats per input beat
  class slice_sched_sb;
    logic [ID_W-1:0]    tbl_id    [TABLE_DEPTH];
    logic [SLICE_W-1:0] tbl_ms    [TABLE_DEPTH];
    logic [CODE_W-1:0]  tbl_code  [TABLE_DEPTH];
    bit                 tbl_valid [TABLE_DEPTH];
    logic [CNT_W-1:0]   used_n;
    logic [SLOT_W-1:0]  scan_from;
    bit                 busy;
    logic [SLICE_W-1:0] ms_left;
    logic [ID_W-1:0]    cur_id;
    logic [CODE_W-1:0]  cur_code;
    result_t            due_q[$];
    int unsigned        errors;

    function new();
      foreach (tbl_valid[i]) tbl_valid[i] = 0;
      used_n    = '0;
      scan_from = '0;
      busy      = 0;
      ms_left   = '0;
      cur_id    = '0;
      cur_code  = '0;
      errors    = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void queue_result(event_e k, logic [ID_W-1:0] id, logic [CODE_W-1:0] sig,
                               logic last);
      result_t r;
      r.kind  = k;
      r.ident = id;
      r.sig   = sig;
      r.last  = last;
      due_q.push_back(r);
    endfunction

    // slot of a live client with this id, or -1
    function int find_live(logic [ID_W-1:0] id);
      for (int i = 0; i < used_n && i < TABLE_DEPTH; i++)
        if (tbl_valid[i] && tbl_id[i] == id) return i;
      return -1;
    endfunction

    // round-robin search over the used slots; loads the slice on a hit
    function bit launch_next();
      int n;
      int slot;
      n = (used_n > TABLE_DEPTH) ? TABLE_DEPTH : used_n;
      if (n == 0) return 0;
      slot = (scan_from < n) ? scan_from : 0;
      for (int k = 0; k < n; k++) begin
        if (tbl_valid[slot]) begin
          cur_id    = tbl_id[slot];
          cur_code  = tbl_code[slot];
          ms_left   = (tbl_ms[slot] != 0) ? tbl_ms[slot] : SLICE_W'(1);
          busy      = 1;
          scan_from = SLOT_W'((slot + 1 < n) ? slot + 1 : 0);
          return 1;
        end
        slot = (slot + 1 < n) ? slot + 1 : 0;
      end
      return 0;
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                             logic [SLICE_W-1:0] ms, logic [CODE_W-1:0] code);
      int idx;
      idx = find_live(id);
      case (op)
        OP_REGISTER: begin
          if (idx >= 0) begin
            queue_result(EV_DUP, id, '0, 1'b1);
          end else if (used_n >= TABLE_DEPTH) begin
            queue_result(EV_FULL, id, '0, 1'b1);
          end else begin
            tbl_id[used_n]    = id;
            tbl_ms[used_n]    = ms;
            tbl_code[used_n]  = code;
            tbl_valid[used_n] = 1;
            used_n++;
            queue_result(EV_ADDED, id, '0, 1'b1);
          end
        end
        OP_REMOVE: begin
          if (idx >= 0) begin
            tbl_valid[idx] = 0;
            queue_result(EV_REMOVED, id, '0, 1'b1);
          end else begin
            queue_result(EV_NOTFOUND, id, '0, 1'b1);
          end
        end
        OP_TICK: begin
          if (busy) begin
            // mid-slice tick: count down silently
            if (ms_left > 1) begin
              ms_left--;
              return;
            end
            ms_left = '0;
            busy    = 0;
            queue_result(EV_STOP, cur_id, cur_code, 1'b0);
          end
          if (launch_next()) queue_result(EV_START, cur_id, cur_code, 1'b1);
          else queue_result(EV_IDLE, '0, '0, 1'b1);
        end
        default: ;  // unused operation code causes nothing
      endcase
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                               logic [CODE_W-1:0] sig, logic last);
      result_t want;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual kind %0d id %0d",
                 $time, kind, id);
        errors++;
        return;
      end
      want = due_q.pop_front();
      cmp_field("event_kind", want.kind, kind);
      cmp_field("target_id", want.ident, id);
      cmp_field("target_signal", want.sig, sig);
      cmp_field("last", want.last, last);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]       s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]     m_axis_tuser;
  logic                  m_axis_tlast;

  slice_sched_sb sb = new();
  bit            tx_calm;       // sender runs without gaps
  bit            rx_calm;       // receiver runs without stalls
  int unsigned   rx_hold;
  logic [ID_W-1:0] known_ids[$];

  round_robin_slice_scheduler i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // client_id, slice_ms, signal_code
    .s_axis_tuser  (s_axis_tuser),   // operation
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // target_id, target_signal
    .m_axis_tuser  (m_axis_tuser),   // event_kind
    .m_axis_tlast  (m_axis_tlast)    // last
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // result side: random stall after each beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        rx_hold = rx_calm ? 0 : $urandom_range(0, 3);
        m_axis_tready <= (rx_hold == 0);
      end else if (!m_axis_tready) begin
        if (rx_hold > 1) begin
          rx_hold--;
        end else begin
          rx_hold = 0;
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[ID_W-1:0], m_axis_tdata[ID_W +: CODE_W],
                      m_axis_tlast);
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // one input beat, after a random gap; returns once it is accepted
  task automatic send_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                           logic [SLICE_W-1:0] ms, logic [CODE_W-1:0] code);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, code, ms, id};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, id, ms, code);
  endtask

  // hold off the sender until every predicted beat has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic send_random();
    int unsigned      pick;
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic [SLICE_W-1:0] ms;
    logic [CODE_W-1:0] code;
    pick = $urandom_range(0, 99);
    id   = ID_W'($urandom);
    ms   = SLICE_W'($urandom_range(0, 999));
    code = CODE_W'($urandom_range(0, 31));
    if (pick < 5) begin
      op = OP_REGISTER;
      case ($urandom_range(0, 3))
        0, 1: id = ID_W'($urandom_range(0, 31));
        2:    id = known_ids[$urandom_range(0, known_ids.size() - 1)];
        default: ;
      endcase
      // keep live slices short so rotations happen often
      if (sb.used_n < TABLE_DEPTH) ms = SLICE_W'($urandom_range(0, 12));
      known_ids.push_back(id);
    end else if (pick < 8) begin
      op = OP_REMOVE;
      if ($urandom_range(0, 4) < 3) id = known_ids[$urandom_range(0, known_ids.size() - 1)];
      else if ($urandom_range(0, 1)) id = ID_W'($urandom_range(0, 31));
    end else if (pick == 8) begin
      op = OP_UNUSED;
    end else begin
      op = OP_TICK;
    end
    send_item(op, id, ms, code);
  endtask

  initial begin : stimulus
    tx_calm = 0;
    rx_calm = 0;
    known_ids.push_back('0);
    known_ids.push_back(ID_MAX);
    known_ids.push_back(ID_W'(3));
    wait (rst_ni);
    @(posedge clk_i);

    send_item(OP_TICK, '0, '0, '0);                 // empty table: idle
    send_item(OP_UNUSED, ID_W'(5), '0, '0);         // ignored
    send_item(OP_REMOVE, ID_W'(5), '0, '0);         // remove miss
    send_item(OP_REGISTER, '0, '0, '0);             // zero slice client
    send_item(OP_REGISTER, '0, SLICE_W'(7), CODE_W'(9));   // duplicate
    send_item(OP_REGISTER, ID_MAX, SLICE_W'(999), CODE_W'(31));
    send_item(OP_TICK, '0, '0, '0);                 // start id 0
    send_item(OP_REMOVE, ID_MAX, '0, '0);           // removed before it ran
    send_item(OP_TICK, '0, '0, '0);                 // stop, skip invalid, restart
    send_item(OP_REGISTER, ID_W'(3), SLICE_W'(2), CODE_W'(17));
    send_item(OP_TICK, '0, '0, '0);                 // stop id 0, start id 3
    send_item(OP_REMOVE, ID_W'(3), '0, '0);         // remove the active client
    send_item(OP_TICK, ID_MAX, SLICE_W'(999), CODE_W'(31));  // mid-slice
    send_item(OP_TICK, '0, '0, '0);                 // removed client still stops
    send_item(OP_REMOVE, '0, '0, '0);
    send_item(OP_TICK, '0, '0, '0);                 // stop with nothing to follow
    send_item(OP_TICK, '0, '0, '0);                 // not running, no client
    send_item(OP_REGISTER, '0, SLICE_W'(1), CODE_W'(31));   // id reused in new slot
    send_item(OP_REMOVE, ID_MAX, '0, '0);           // already removed
    send_item(OP_TICK, '0, '0, '0);
    drain_results();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 64 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      if (n % 256 == 255) drain_results();
      send_random();
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/rrss_pkg.sv
src/rrss_table.sv
src/rrss_ctrl.sv
src/rrss_obuf.sv
src/round_robin_slice_scheduler.sv
src/rrss_checker.sv
test/tb.sv
